/* rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the sextet-to-character mapping of the
// base64 stream encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned MAX_CHARS  = 4;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;

  typedef logic [CHAR_W-1:0] b64e_char_t;

  // one accepted byte worth of output characters
  typedef struct packed {
    b64e_char_t [MAX_CHARS-1:0] chars;
    logic [IDX_W-1:0]           last_idx;
    logic                       msg_end;
  } b64e_entry_t;

  typedef struct packed {
    logic        valid;
    b64e_entry_t entry;
  } b64e_push_t;

  typedef struct packed {
    logic        valid;
    b64e_entry_t entry;
  } b64e_head_t;

  function automatic b64e_char_t sextet_char(input logic [5:0] v);
    b64e_char_t ch;
    ch = '0;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      ch = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

/* rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// accepts raw bytes, tracks leftover bits and group phase, and builds the
// character list that each byte produces
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       message_last,
  output b64e_push_t push
);

  logic [3:0] leftover_bits_r, leftover_bits_nxt;
  logic [2:0] leftover_count_r, leftover_count_nxt;
  logic [1:0] group_phase_r, group_phase_nxt;

  b64e_char_t c0, c1, flush_char;
  logic [2:0] k_base, k_tot, pads, n_tot;
  logic [1:0] phase_after;
  logic [3:0] rem_bits;
  logic [2:0] rem_count;
  logic       do_flush;

  always_comb begin
    c0        = sextet_char(data_byte[7:2]);
    c1        = PAD_CHAR;
    k_base    = 3'd1;
    rem_bits  = {2'b00, data_byte[1:0]};
    rem_count = 3'd2;
    case (leftover_count_r)
      3'd2: begin
        c0        = sextet_char({leftover_bits_r[1:0], data_byte[7:4]});
        rem_bits  = data_byte[3:0];
        rem_count = 3'd4;
      end
      3'd4: begin
        c0        = sextet_char({leftover_bits_r[3:0], data_byte[7:6]});
        c1        = sextet_char(data_byte[5:0]);
        k_base    = 3'd2;
        rem_bits  = 4'd0;
        rem_count = 3'd0;
      end
      default: begin
      end
    endcase

    // leftover bits zero-padded on the right
    flush_char = (rem_count == 3'd4) ? sextet_char({rem_bits, 2'b00})
                                     : sextet_char({rem_bits[1:0], 4'b0000});
    do_flush   = message_last && (rem_count != 3'd0);
    k_tot      = k_base + {2'b00, do_flush};

    phase_after = group_phase_r + k_tot[1:0];
    pads        = (phase_after == 2'd0) ? 3'd0 : 3'd4 - {1'b0, phase_after};
    n_tot       = message_last ? k_tot + pads : k_base;
    if (n_tot > 3'd4) begin
      n_tot = 3'd4;
    end

    push.valid          = accept;
    push.entry.chars[0] = c0;
    push.entry.chars[1] = (k_base == 3'd2) ? c1 : (do_flush ? flush_char : PAD_CHAR);
    push.entry.chars[2] = PAD_CHAR;
    push.entry.chars[3] = PAD_CHAR;
    push.entry.last_idx = IDX_W'(n_tot - 3'd1);
    push.entry.msg_end  = message_last;

    leftover_bits_nxt  = leftover_bits_r;
    leftover_count_nxt = leftover_count_r;
    group_phase_nxt    = group_phase_r;
    if (accept) begin
      if (message_last) begin
        leftover_bits_nxt  = '0;
        leftover_count_nxt = '0;
        group_phase_nxt    = '0;
      end else begin
        leftover_bits_nxt  = rem_bits;
        leftover_count_nxt = rem_count;
        group_phase_nxt    = group_phase_r + k_base[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leftover_bits_r  <= '0;
      leftover_count_r <= '0;
      group_phase_r    <= '0;
    end else begin
      leftover_bits_r  <= leftover_bits_nxt;
      leftover_count_r <= leftover_count_nxt;
      group_phase_r    <= group_phase_nxt;
    end
  end

endmodule

/* rtl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// two-entry queue of character lists between front and back
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64e_push_t push,
  input  logic       pop,
  output logic       full,
  output b64e_head_t head
);

  b64e_entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]        count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// walks the queued character list one character per cycle into the
// output register while that register is empty or being taken
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  b64e_head_t head,
  output logic       pop,
  input  logic       out_ready,
  output logic       out_valid,
  output b64e_char_t out_char,
  output logic       out_run_last,
  output logic       out_msg_end
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  b64e_char_t       char_r, char_nxt;
  logic             run_last_r, run_last_nxt;
  logic             msg_end_r, msg_end_nxt;
  logic             load, at_last;

  assign load    = head.valid && (!valid_r || out_ready);
  assign at_last = (idx_r == head.entry.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    char_nxt     = char_r;
    run_last_nxt = run_last_r;
    msg_end_nxt  = msg_end_r;
    if (load) begin
      valid_nxt    = 1'b1;
      char_nxt     = head.entry.chars[idx_r];
      run_last_nxt = at_last;
      msg_end_nxt  = at_last && head.entry.msg_end;
      idx_nxt      = at_last ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    char_r     <= char_nxt;
    run_last_r <= run_last_nxt;
    msg_end_r  <= msg_end_nxt;
  end

  assign out_valid    = valid_r;
  assign out_char     = char_r;
  assign out_run_last = run_last_r;
  assign out_msg_end  = msg_end_r;

endmodule

/* rtl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// byte stream to base64 character stream, with flush and '=' padding at
// the end of each message
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tlast        | tuser
//  in_     | in  | [7:0] data_byte        | message_last | -
//  out_    | out | [6:0] out_char, [7] 0  | run_last     | message_end
//
//  one character leaves per cycle from the output register when not stalled;
//  a byte gives one or two characters, a last byte up to four
//  a byte is taken each cycle while the two-entry queue has room
//  reset clears leftover bits, group phase, queue and output valid
//  a stalled output holds its word; the front keeps taking bytes until the
//  queue fills
// ----------------------------------------------------------------------------
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast,
  output logic       out_tuser   // [0] message_end
);

  b64e_push_t push;
  b64e_head_t head;
  logic       q_full, pop, accept;
  b64e_char_t out_char;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata),
    .message_last (in_tlast),
    .push         (push)
  );

  b64e_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  b64e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .pop          (pop),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_char     (out_char),
    .out_run_last (out_tlast),
    .out_msg_end  (out_tuser)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

/* rtl/b64e_checker.sv */
// ----------------------------------------------------------------------------
// b64e_checker
// port-level checks on the base64 stream encoder
// ----------------------------------------------------------------------------
module b64e_checker
  import b64e_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed under stall");

  // message end is always the last character of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("message end without run last");

  // padding never precedes a data character within a byte's run
  a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast && out_tdata[6:0] == PAD_CHAR
      |=> !out_tvalid || out_tdata[6:0] == PAD_CHAR)
    else $error("data character after padding");

  // no output straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (.*);

/* tb/base64_stream_encoder_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_check
// watches both stream channels of the encoder, predicts the base64
// characters of every accepted byte and compares each output word in order
// ----------------------------------------------------------------------------
module base64_stream_encoder_check
  import b64e_pkg::PAD_CHAR;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int unsigned mismatches,
  output int unsigned chars_pending,
  output int unsigned chars_checked
);

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       msg_end;
  } encoded_char_t;

  encoded_char_t expected_chars[$];

  logic [3:0]  held_bits;
  logic [2:0]  held_count;
  logic [1:0]  group_pos;
  int unsigned err_total;
  int unsigned ok_total;

  function automatic logic [6:0] char_of(input logic [5:0] sextet);
    logic [7:0] code;
    code = ALPHABET[8*(63-sextet) +: 8];
    return code[6:0];
  endfunction

  task automatic encode_byte(input logic [7:0] data_byte, input logic msg_last);
    logic [11:0]   acc;
    int            nbits;
    int            made;
    encoded_char_t burst [4];
    if (held_count == 3'd2) begin
      acc   = {2'b00, held_bits[1:0], data_byte};
      nbits = 10;
    end else if (held_count == 3'd4) begin
      acc   = {held_bits, data_byte};
      nbits = 12;
    end else begin
      acc   = {4'h0, data_byte};
      nbits = 8;
    end
    made = 0;
    while (nbits >= 6) begin
      nbits -= 6;
      burst[made] = '{ch: char_of(6'(acc >> nbits)), run_last: 1'b0, msg_end: 1'b0};
      made++;
      group_pos++;
    end
    acc &= (12'h1 << nbits) - 12'h1;
    if (msg_last) begin
      if (nbits > 0) begin
        burst[made] = '{ch: char_of(6'(acc << (6 - nbits))), run_last: 1'b0,
                        msg_end: 1'b0};
        made++;
        group_pos++;
      end
      while (group_pos != 2'd0 && made < 4) begin
        burst[made] = '{ch: PAD_CHAR, run_last: 1'b0, msg_end: 1'b0};
        made++;
        group_pos++;
      end
      burst[made-1].msg_end = 1'b1;
      held_bits  = 4'h0;
      held_count = 3'd0;
      group_pos  = 2'd0;
    end else begin
      held_bits  = acc[3:0];
      held_count = nbits[2:0];
    end
    burst[made-1].run_last = 1'b1;
    for (int i = 0; i < made; i++) expected_chars.insert(expected_chars.size(), burst[i]);
  endtask

  always @(posedge clk) begin : monitor
    encoded_char_t want;
    if (!rst_n) begin
      expected_chars.delete();
      held_bits  = 4'h0;
      held_count = 3'd0;
      group_pos  = 2'd0;
      err_total  = 0;
      ok_total   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word: out_tdata %h out_tlast %b out_tuser %b",
                 out_tdata, out_tlast, out_tuser);
          err_total++;
        end else begin
          want = expected_chars.pop_front();
          ok_total++;
          if (out_tdata[6:0] !== want.ch) begin
            $error("out_char: expected %h, actual %h", want.ch, out_tdata[6:0]);
            err_total++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $error("out_tdata pad bit: expected 0, actual %b", out_tdata[7]);
            err_total++;
          end
          if (out_tlast !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, out_tlast);
            err_total++;
          end
          if (out_tuser !== want.msg_end) begin
            $error("message_end: expected %b, actual %b", want.msg_end, out_tuser);
            err_total++;
          end
        end
      end
      if (in_tvalid && in_tready) encode_byte(in_tdata, in_tlast);
    end
    mismatches    <= err_total;
    chars_pending <= expected_chars.size();
    chars_checked <= ok_total;
  end

endmodule

/* tb/base64_stream_encoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// drives byte messages into the base64 stream encoder, directed corner
// messages first and random messages after, with random stalls on both
// channels; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 20;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned chars_checked;

  bit          quiet        = 1'b0;
  bit          gaps_on      = 1'b1;
  bit          hold_request = 1'b0;
  bit          hold_active  = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned bytes_sent   = 0;
  int unsigned msgs_sent    = 0;

  always #5 clk = ~clk;

  base64_stream_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  base64_stream_encoder_check i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  task automatic send_byte(input logic [7:0] data_byte, input logic msg_last);
    in_tvalid <= 1'b1;
    in_tdata  <= data_byte;
    in_tlast  <= msg_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (msg_last) msgs_sent++;
    if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin : receiver
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one, two and three byte messages, all-zero and all-one bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    // top of the alphabet: plus and slash
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // longer messages crossing group boundaries, bytes continue the message
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);

    // sender pause until every character is out
    wait_drained();

    // long receiver hold while bytes keep coming
    hold_request = 1'b1;
    gaps_on      = 1'b0;
    while (!hold_active) @(posedge clk);
    send_random_message(24);
    in_tvalid <= 1'b0;
    while (!hold_done) @(posedge clk);
    hold_request = 1'b0;
    gaps_on      = 1'b1;

    while (bytes_sent < 190) begin
      if ($urandom_range(0, 4) == 0) send_random_message($urandom_range(7, 16));
      else send_random_message($urandom_range(1, 6));
    end

    // closing stretch with both sides always ready
    quiet = 1'b1;
    while (bytes_sent < 230) send_random_message($urandom_range(1, 6));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d messages sent, %0d characters checked",
             bytes_sent, msgs_sent, chars_checked);
    $display("covered all group phases, padding, stalls on both sides and a full input");
    if (mismatches == 0 && chars_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
rtl/b64e_checker.sv
tb/base64_stream_encoder_check.sv
tb/base64_stream_encoder_test.sv
